// ===== rtl/cvm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvm_pkg
// Shared types and constants of the cell voltage monitor.
// ----------------------------------------------------------------------------
package cvm_pkg;

    localparam int unsigned CVM_MAX_CELLS   = 12;
    localparam int unsigned CELL_LIMIT      = 12;
    localparam int unsigned CFG_INDEX_W     = 2;
    localparam int unsigned CFG_DATA_W      = 13;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam logic [4:0]  FRAME_BYTES     = 5'd18;
    localparam logic [12:0] CODE_OFFSET     = 13'd512;

    localparam logic [3:0]  CELL_COUNT_RST  = 4'd12;
    localparam logic [12:0] UNDER_LIMIT_RST = 13'd2000;
    localparam logic [12:0] OVER_LIMIT_RST  = 13'd2800;

    localparam logic [CFG_INDEX_W-1:0] REG_CELL_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNDER_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OVER_LIMIT  = 2'd2;

    typedef enum logic [1:0] {
        CLASS_IN_RANGE = 2'd0,
        CLASS_UNDER    = 2'd1,
        CLASS_OVER     = 2'd2
    } level_class_t;

    typedef struct packed {
        logic [3:0]  cell_index;
        logic [11:0] raw_code;
        logic        last_cell;
    } cvm_cell_t;

    typedef struct packed {
        logic signed [12:0] under_limit;
        logic signed [12:0] over_limit;
    } cvm_limits_t;

    typedef struct packed {
        logic [3:0]         cell_index;
        logic signed [12:0] cell_code;
        level_class_t       level_class;
        logic               under_flag;
        logic               over_flag;
        logic [11:0]        discharge_mask;
        logic               last_cell;
    } cvm_result_t;

endpackage
`default_nettype wire

// ===== rtl/cvm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvm_front
// Byte unpacker: tracks the frame position and joins byte pairs into
// 12-bit cell readings for the cells in use.
// ----------------------------------------------------------------------------
module cvm_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_byte,
    input  wire logic             s_start,
    input  wire logic [3:0]       used_cells,
    output logic                  push,
    output cvm_pkg::cvm_cell_t    push_data,
    input  wire logic             queue_full
);
    import cvm_pkg::*;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    logic [4:0] pos_reg, pos_next, pos_cur;
    logic [1:0] phase_reg, phase_next, phase_cur;
    logic [2:0] pair_reg, pair_next, pair_cur;
    logic [7:0] prev_reg;
    logic       accept, in_frame;
    logic [3:0] cell_idx;
    logic [11:0] raw;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_cur   = s_start ? 5'd0 : pos_reg;
        phase_cur = s_start ? PHASE_FIRST : phase_reg;
        pair_cur  = s_start ? 3'd0 : pair_reg;
        in_frame  = pos_cur < FRAME_BYTES;
        cell_idx  = {pair_cur, phase_cur == PHASE_THIRD};
        raw = (phase_cur == PHASE_SECOND) ? {s_byte[3:0], prev_reg}
                                          : {s_byte, prev_reg[7:4]};
        push = accept && in_frame && (phase_cur != PHASE_FIRST) && (cell_idx < used_cells);
        push_data.cell_index = cell_idx;
        push_data.raw_code   = raw;
        push_data.last_cell  = (cell_idx + 4'd1) == used_cells;

        pos_next   = pos_cur;
        phase_next = phase_cur;
        pair_next  = pair_cur;
        if (in_frame) begin
            pos_next = pos_cur + 5'd1;
            if (phase_cur == PHASE_THIRD) begin
                phase_next = PHASE_FIRST;
                pair_next  = pair_cur + 3'd1;
            end else begin
                phase_next = phase_cur + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 5'd0;
            phase_reg <= PHASE_FIRST;
            pair_reg  <= 3'd0;
            prev_reg  <= 8'd0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            pair_reg  <= pair_next;
            prev_reg  <= s_byte;
        end
    end

`ifndef SYNTH
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= FRAME_BYTES && phase_reg != 2'd3)
        else $error("frame position out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/cvm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvm_queue
// Short queue of unpacked cell readings between the unpacker and the
// classifier.
// ----------------------------------------------------------------------------
module cvm_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  cvm_pkg::cvm_cell_t push_data,
    output logic               full,
    input  wire logic          pop,
    output cvm_pkg::cvm_cell_t pop_data,
    output logic               empty
);
    import cvm_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cvm_cell_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/cvm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvm_back
// Classifier: removes the offset, compares against the limits, keeps the
// per-cell flags (cleared by an in-range reading) and holds the result register.
// ----------------------------------------------------------------------------
module cvm_back #(
    parameter int unsigned MAX_CELLS = cvm_pkg::CVM_MAX_CELLS
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            empty,
    output logic                 pop,
    input  cvm_pkg::cvm_cell_t   pop_data,
    input  cvm_pkg::cvm_limits_t limits,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output cvm_pkg::cvm_result_t m_result
);
    import cvm_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_CELLS);

    logic [MAX_CELLS-1:0] under_reg, under_next;
    logic [MAX_CELLS-1:0] over_reg, over_next;
    logic [MAX_CELLS-1:0] cell_bit;
    logic [IDX_W-1:0]     idx;
    logic signed [12:0]   code;
    level_class_t         cls;
    logic                 m_valid_reg;
    cvm_result_t          result_reg, result_next;

    assign pop      = !empty && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    always_comb begin
        idx        = pop_data.cell_index[IDX_W-1:0];
        cell_bit   = MAX_CELLS'(1) << idx;
        code       = $signed({1'b0, pop_data.raw_code} - CODE_OFFSET);
        under_next = under_reg;
        over_next  = over_reg;
        if (code <= limits.under_limit) begin
            cls        = CLASS_UNDER;
            under_next = under_reg | cell_bit;
        end else if (code >= limits.over_limit) begin
            cls       = CLASS_OVER;
            over_next = over_reg | cell_bit;
        end else begin
            cls        = CLASS_IN_RANGE;
            under_next = under_reg & ~cell_bit;
            over_next  = over_reg & ~cell_bit;
        end
        result_next.cell_index     = pop_data.cell_index;
        result_next.cell_code      = code;
        result_next.level_class    = cls;
        result_next.under_flag     = under_next[idx];
        result_next.over_flag      = over_next[idx];
        result_next.discharge_mask = CELL_LIMIT'(over_next);
        result_next.last_cell      = pop_data.last_cell;
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            under_reg   <= '0;
            over_reg    <= '0;
        end else begin
            if (pop) begin
                m_valid_reg <= 1'b1;
                under_reg   <= under_next;
                over_reg    <= over_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_mask_tracks_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> result_reg.discharge_mask == CELL_LIMIT'(over_reg))
        else $error("discharge mask differs from over flags");
    a_in_range_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.level_class == CLASS_IN_RANGE
            |-> !result_reg.under_flag && !result_reg.over_flag)
        else $error("in-range reading left a flag set");
    a_under_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.level_class == CLASS_UNDER |-> result_reg.under_flag)
        else $error("under reading without under flag");
`endif

endmodule
`default_nettype wire

// ===== rtl/cell_voltage_monitor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cell_voltage_monitor
// Battery cell over/under voltage monitor on the cell voltage readback.
// ----------------------------------------------------------------------------
// Input stream carries one readback byte per transfer in s_tdata, with
// s_tuser set on the first byte of a frame. Each group of three bytes holds
// two 12-bit cell readings; the second and third byte of a group each
// complete one cell and, if that cell is in use, produce one result transfer
// on the m_ stream. Bytes past the eighteenth are dropped until the next
// frame start.
// Throughput: one byte per cycle while s_tready is high; the unpacker writes the
// two-entry queue in the cycle its completing byte is accepted, and the classifier
// pops that entry into the result register, which drives m_tvalid.
// When m_tready is low the result register holds, the queue fills, and then
// s_tready drops until the classifier can move again.
// Reset clears frame position, per-cell flags and both streams, and loads
// cell_count 12, under_limit 2000, over_limit 2800. The user must make writes
// via cfg_we/cfg_index/cfg_wdata while the block is idle; it does not enforce it.
// ----------------------------------------------------------------------------
module cell_voltage_monitor #(
    parameter int unsigned MAX_CELLS = cvm_pkg::CVM_MAX_CELLS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [cvm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [cvm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [7:0]                           s_tdata,  // read_byte
    input  wire logic                                 s_tuser,  // frame_start
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // cell_index, cell_code, level_class, under_flag, over_flag,
    // discharge_mask, zero fill
    output logic [39:0]                               m_tdata,
    output logic                                      m_tlast   // last_cell
);
    import cvm_pkg::*;

    logic [3:0]  cell_count_reg;
    logic [12:0] under_limit_reg, over_limit_reg;
    logic [3:0]  used_cells;
    cvm_limits_t limits;
    logic        push, pop, full, empty;
    cvm_cell_t   push_data, pop_data;
    cvm_result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg  <= CELL_COUNT_RST;
            under_limit_reg <= UNDER_LIMIT_RST;
            over_limit_reg  <= OVER_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CELL_COUNT:  cell_count_reg  <= cfg_wdata[3:0];
                REG_UNDER_LIMIT: under_limit_reg <= cfg_wdata;
                REG_OVER_LIMIT:  over_limit_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign used_cells = (cell_count_reg > 4'(MAX_CELLS)) ? 4'(MAX_CELLS) : cell_count_reg;
    assign limits.under_limit = $signed(under_limit_reg);
    assign limits.over_limit  = $signed(over_limit_reg);

    cvm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_byte     (s_tdata),
        .s_start    (s_tuser),
        .used_cells (used_cells),
        .push       (push),
        .push_data  (push_data),
        .queue_full (full)
    );

    cvm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    cvm_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .pop      (pop),
        .pop_data (pop_data),
        .limits   (limits),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {7'd0, result.discharge_mask, result.over_flag, result.under_flag,
                      result.level_class, result.cell_code, result.cell_index};
    assign m_tlast = result.last_cell;

endmodule
`default_nettype wire
